// ===== sv/rate_limited_can_telemetry_framer_macros.svh =====
// Assertion macros shared by the framer RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef RATE_LIMITED_CAN_TELEMETRY_FRAMER_MACROS_SVH
`define RATE_LIMITED_CAN_TELEMETRY_FRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define RLCTF_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RLCTF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rlctf_pkg.sv =====
// Package for the rate-limited CAN telemetry framer: item types,
// frame constants, register indexes and the frame builder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rlctf_pkg;

  localparam int ID_BITS     = 11;
  localparam int TS_BITS     = 29;
  localparam int LEN_BITS    = 4;
  localparam int PERIOD_BITS = 16;
  localparam int HDR_BYTES   = 5;
  localparam int DATA_BYTES  = 8;
  localparam int FRAME_BYTES = HDR_BYTES + DATA_BYTES;
  localparam int HDR_BITS    = HDR_BYTES * 8;
  localparam int FRAME_BITS  = FRAME_BYTES * 8;
  localparam int CNT_BITS    = $clog2(FRAME_BYTES);

  localparam logic [ID_BITS-1:0]     LIVE_ID_A_RST  = 11'd1320;
  localparam logic [ID_BITS-1:0]     LIVE_ID_B_RST  = 11'd48;
  localparam logic [PERIOD_BITS-1:0] MIN_PERIOD_RST = 16'd100;

  // Register map, one word per register
  typedef enum logic [1:0] {
    REG_LIVE_ID_A    = 2'd0,
    REG_LIVE_ID_B    = 2'd1,
    REG_MIN_PERIOD_A = 2'd2,
    REG_MIN_PERIOD_B = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  can_id;
    logic [TS_BITS-1:0]  timestamp;
    logic [LEN_BITS-1:0] data_len;
    logic [7:0]          payload_0;
    logic [7:0]          payload_1;
    logic [7:0]          payload_2;
    logic [7:0]          payload_3;
    logic [7:0]          payload_4;
    logic [7:0]          payload_5;
    logic [7:0]          payload_6;
    logic [7:0]          payload_7;
  } can_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } tlm_item_t;

  // Whole frame, byte 0 in the low bits
  typedef logic [FRAME_BITS-1:0] frame_t;

  // Serialiser status seen by the decision stage
  typedef struct packed {
    logic free;
    logic busy;
  } ser_status_t;

  // Header {timestamp, id} little endian, then masked payload bytes
  function automatic frame_t build_frame(can_item_t it);
    logic [7:0] data [DATA_BYTES];
    frame_t     f;
    data[0] = it.payload_0;
    data[1] = it.payload_1;
    data[2] = it.payload_2;
    data[3] = it.payload_3;
    data[4] = it.payload_4;
    data[5] = it.payload_5;
    data[6] = it.payload_6;
    data[7] = it.payload_7;
    f = '0;
    f[HDR_BITS-1:0] = {it.timestamp, it.can_id};
    for (int k = 0; k < DATA_BYTES; k++) begin
      f[HDR_BITS + 8*k +: 8] = (LEN_BITS'(k) < it.data_len) ? data[k] : 8'h00;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rlctf_serializer.sv =====
// Frame serialiser: holds one 13-byte frame and sends it a byte per item.
// Depends on rlctf_pkg and the framer assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "rate_limited_can_telemetry_framer_macros.svh"

module rlctf_serializer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire rlctf_pkg::frame_t   frame,
  output rlctf_pkg::ser_status_t   status,
  output logic                     tlm_valid,
  input  wire logic                tlm_stall,
  output rlctf_pkg::tlm_item_t     tlm_item
);

  localparam logic [rlctf_pkg::CNT_BITS-1:0] LAST_IDX =
    rlctf_pkg::CNT_BITS'(rlctf_pkg::FRAME_BYTES - 1);

  logic                          valid;
  logic [rlctf_pkg::CNT_BITS-1:0] count;
  rlctf_pkg::frame_t             shreg;
  logic                          last;
  logic                          take;

  assign last = (count == LAST_IDX);
  assign take = valid && !tlm_stall;

  // Free when empty or when the final byte leaves this cycle
  assign status.free = !valid || (take && last);
  assign status.busy = valid;

  // Control: valid flag and byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      count <= '0;
    end else if (load) begin
      valid <= 1'b1;
      count <= '0;
    end else if (take) begin
      if (last) begin
        valid <= 1'b0;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  // Payload shift register, next byte always at the bottom
  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= frame;
    end else if (take) begin
      shreg <= shreg >> 8;
    end
  end

  assign tlm_valid          = valid;
  assign tlm_item.out_byte  = shreg[7:0];
  assign tlm_item.frame_end = last;

  `RLCTF_ASSERT_SAME(a_load_when_free, load, status.free, "frame loaded over a busy serialiser")
  `RLCTF_ASSERT_SAME(a_count_range, valid, count <= LAST_IDX, "byte counter past frame end")
  `RLCTF_ASSERT_NEXT(a_drain_after_last, take && last && !load, !valid,
                     "serialiser still valid after last byte")

endmodule

`default_nettype wire

// ===== sv/rate_limited_can_telemetry_framer.sv =====
// Top level of the rate-limited CAN telemetry framer: APB registers,
// input register, per-entry rate check and the frame serialiser.
// Depends on rlctf_pkg, rlctf_serializer and the assertion macros.
//
//  channel | direction | payload          | handshake
//  can     | in        | can_item_t       | can_valid / can_stall
//  tlm     | out       | tlm_item_t       | tlm_valid / tlm_stall
//  apb     | in        | 32-bit registers | psel / penable / pwrite, pready high
//
// A forwarded frame leaves as 13 byte items, one per cycle while tlm is not
// stalled; the byte-wide serialiser sets the sustained rate of forwarded frames.
// A frame that is filtered out or rate limited is consumed without waiting.
// The input register takes the next frame while the current one is sent.
// rst is synchronous: clears valids, last-sent times and restores registers.
// A stall on tlm holds the byte; can_stall rises only when the input
// register holds a forwarded frame that the serialiser cannot yet take.
`timescale 1ns / 1ps
`default_nettype none
`include "rate_limited_can_telemetry_framer_macros.svh"

module rate_limited_can_telemetry_framer #(
  parameter int LIVE_ENTRIES = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // CAN frames in
  input  wire logic                 can_valid,
  output logic                      can_stall,
  input  wire rlctf_pkg::can_item_t can_item,
  // telemetry bytes out
  output logic                      tlm_valid,
  input  wire logic                 tlm_stall,
  output rlctf_pkg::tlm_item_t      tlm_item,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int TSX = rlctf_pkg::TS_BITS + 1;

  logic [rlctf_pkg::ID_BITS-1:0]     live_id_a;
  logic [rlctf_pkg::ID_BITS-1:0]     live_id_b;
  logic [rlctf_pkg::PERIOD_BITS-1:0] min_period_a;
  logic [rlctf_pkg::PERIOD_BITS-1:0] min_period_b;

  logic [rlctf_pkg::TS_BITS-1:0] last_sent_time [LIVE_ENTRIES];

  logic                   in_valid_r;
  rlctf_pkg::can_item_t   in_item_r;
  logic                   can_take;
  logic                   consume;
  logic                   send;
  logic [LIVE_ENTRIES-1:0] entry_send;
  rlctf_pkg::ser_status_t ser_status;
  rlctf_pkg::reg_idx_t    reg_idx;
  logic                   reg_wr;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = rlctf_pkg::reg_idx_t'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      live_id_a    <= rlctf_pkg::LIVE_ID_A_RST;
      live_id_b    <= rlctf_pkg::LIVE_ID_B_RST;
      min_period_a <= rlctf_pkg::MIN_PERIOD_RST;
      min_period_b <= rlctf_pkg::MIN_PERIOD_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        rlctf_pkg::REG_LIVE_ID_A:    live_id_a    <= pwdata[rlctf_pkg::ID_BITS-1:0];
        rlctf_pkg::REG_LIVE_ID_B:    live_id_b    <= pwdata[rlctf_pkg::ID_BITS-1:0];
        rlctf_pkg::REG_MIN_PERIOD_A: min_period_a <= pwdata[rlctf_pkg::PERIOD_BITS-1:0];
        rlctf_pkg::REG_MIN_PERIOD_B: min_period_b <= pwdata[rlctf_pkg::PERIOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rlctf_pkg::REG_LIVE_ID_A:    prdata = 32'(live_id_a);
      rlctf_pkg::REG_LIVE_ID_B:    prdata = 32'(live_id_b);
      rlctf_pkg::REG_MIN_PERIOD_A: prdata = 32'(min_period_a);
      rlctf_pkg::REG_MIN_PERIOD_B: prdata = 32'(min_period_b);
      default:                     prdata = '0;
    endcase
  end

  // Input register
  assign can_stall = in_valid_r && !consume;
  assign can_take  = can_valid && !can_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
    end else if (can_take) begin
      in_valid_r <= 1'b1;
    end else if (consume) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take) begin
      in_item_r <= can_item;
    end
  end

  // Per-entry match and rate check: send when ts > last + period
  for (genvar e = 0; e < LIVE_ENTRIES; e++) begin : g_entry
    logic [TSX-1:0] thresh;
    logic [TSX-1:0] ts_ext;
    assign ts_ext = {1'b0, in_item_r.timestamp};
    if (e == 0) begin : g_a
      assign thresh = {1'b0, last_sent_time[e]}
                    + TSX'(min_period_a);
      assign entry_send[e] = (in_item_r.can_id == live_id_a) && (ts_ext > thresh);
    end else if (e == 1) begin : g_b
      // entry a wins when both identifiers are equal
      assign thresh = {1'b0, last_sent_time[e]}
                    + TSX'(min_period_b);
      assign entry_send[e] = (in_item_r.can_id == live_id_b)
                          && (in_item_r.can_id != live_id_a) && (ts_ext > thresh);
    end else begin : g_none
      // no identifier register: never matches
      assign thresh        = '0;
      assign entry_send[e] = 1'b0 && (ts_ext > thresh);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        last_sent_time[e] <= '0;
      end else if (consume && entry_send[e]) begin
        last_sent_time[e] <= in_item_r.timestamp;
      end
    end
  end

  // Filtered items leave at once, forwarded ones wait for the serialiser
  assign send    = |entry_send;
  assign consume = in_valid_r && (!send || ser_status.free);

  rlctf_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (consume && send),
    .frame     (rlctf_pkg::build_frame(in_item_r)),
    .status    (ser_status),
    .tlm_valid (tlm_valid),
    .tlm_stall (tlm_stall),
    .tlm_item  (tlm_item)
  );

  `RLCTF_ASSERT_SAME(a_one_entry, in_valid_r, $onehot0(entry_send), "two entries matched one item")
  `RLCTF_ASSERT_SAME(a_stall_full, can_stall, in_valid_r && send && ser_status.busy,
                     "input stalled without a waiting forwarded item")
  `RLCTF_ASSERT_NEXT(a_time_update, consume && entry_send[0],
                     last_sent_time[0] == $past(in_item_r.timestamp),
                     "last-sent time not updated on forward")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for rate_limited_can_telemetry_framer: directed and
// random CAN frames, APB register changes, random gaps and output stalls.
// Depends on rlctf_pkg and the framer RTL.
`timescale 1ns / 1ps

module tb;

  localparam int          SETTLE_CYCLES = 32;
  localparam logic [28:0] TS_MAX        = '1;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  // block ports, all driven from time zero
  logic                 can_valid = 1'b0;
  logic                 can_stall;
  rlctf_pkg::can_item_t can_item  = '0;
  logic                 tlm_valid;
  logic                 tlm_stall = 1'b0;
  rlctf_pkg::tlm_item_t tlm_item;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [3:0]           paddr     = '0;
  logic [31:0]          pwdata    = '0;
  logic [31:0]          prdata;
  logic                 pready;

  rate_limited_can_telemetry_framer uut (
    .clk       (clk),
    .rst       (rst),
    .can_valid (can_valid),
    .can_stall (can_stall),
    .can_item  (can_item),
    .tlm_valid (tlm_valid),
    .tlm_stall (tlm_stall),
    .tlm_item  (tlm_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // shadow of the registers and of the last-sent times
  logic [10:0] id_a     = rlctf_pkg::LIVE_ID_A_RST;
  logic [10:0] id_b     = rlctf_pkg::LIVE_ID_B_RST;
  logic [15:0] period_a = rlctf_pkg::MIN_PERIOD_RST;
  logic [15:0] period_b = rlctf_pkg::MIN_PERIOD_RST;
  logic [28:0] sent_at [2] = '{29'd0, 29'd0};

  rlctf_pkg::can_item_t frames_todo [$];
  rlctf_pkg::tlm_item_t bytes_due [$];
  rlctf_pkg::tlm_item_t byte_want;

  int     frames_queued = 0;
  int     frames_taken  = 0;
  int     frames_out    = 0;
  int     bytes_out     = 0;
  int     settings      = 1;
  int     errors        = 0;
  int     idle_pct      = 0;
  int     send_gap      = 0;
  int     stall_left    = 0;
  longint now_ms        = 0;

  // Rate check and frame assembly for one accepted CAN item
  function automatic void forward_frame(rlctf_pkg::can_item_t f);
    int                   slot;
    int                   age_ms;
    int                   limit_ms;
    logic [39:0]          hdr;
    logic [7:0]           pl [8];
    rlctf_pkg::tlm_item_t b;
    slot = -1;
    if (f.can_id == id_a) slot = 0;
    else if (f.can_id == id_b) slot = 1;
    if (slot < 0) return;
    age_ms   = int'(f.timestamp) - int'(sent_at[slot]);
    limit_ms = (slot == 0) ? int'(period_a) : int'(period_b);
    if (age_ms <= limit_ms) return;
    sent_at[slot] = f.timestamp;
    hdr = {f.timestamp, f.can_id};
    pl  = '{f.payload_0, f.payload_1, f.payload_2, f.payload_3,
            f.payload_4, f.payload_5, f.payload_6, f.payload_7};
    for (int k = 0; k < 5; k++) begin
      b.out_byte  = hdr[8*k +: 8];
      b.frame_end = 1'b0;
      bytes_due.push_back(b);
    end
    for (int k = 0; k < 8; k++) begin
      b.out_byte  = (k < int'(f.data_len)) ? pl[k] : 8'h00;
      b.frame_end = (k == 7);
      bytes_due.push_back(b);
    end
  endfunction

  function automatic rlctf_pkg::can_item_t mk_frame(logic [10:0] id, logic [28:0] ts,
                                                    logic [3:0] len, logic [63:0] data);
    rlctf_pkg::can_item_t f;
    f.can_id    = id;
    f.timestamp = ts;
    f.data_len  = len;
    f.payload_0 = data[7:0];
    f.payload_1 = data[15:8];
    f.payload_2 = data[23:16];
    f.payload_3 = data[31:24];
    f.payload_4 = data[39:32];
    f.payload_5 = data[47:40];
    f.payload_6 = data[55:48];
    f.payload_7 = data[63:56];
    return f;
  endfunction

  task automatic push_frame(rlctf_pkg::can_item_t f);
    frames_todo.push_back(f);
    frames_queued++;
  endtask

  // Mostly live IDs with time moving forward around the period; some stale
  // timestamps and unknown IDs mixed in
  task automatic push_random(int count);
    rlctf_pkg::can_item_t f;
    int                   r;
    int                   p;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      f.can_id = (r < 45) ? id_a : (r < 85) ? id_b : 11'($urandom);
      p = (f.can_id == id_a) ? int'(period_a) :
          (f.can_id == id_b) ? int'(period_b) : 50;
      if ($urandom_range(0, 99) < 8) begin
        r = $urandom_range(1, 2*p + 2);
        f.timestamp = (now_ms > r) ? 29'(now_ms - r) : 29'd0;
      end else begin
        now_ms += $urandom_range(0, 2*p + 2);
        if (now_ms > TS_MAX) now_ms = TS_MAX;
        f.timestamp = 29'(now_ms);
      end
      f.data_len = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 8))
                                              : 4'($urandom_range(9, 15));
      {f.payload_0, f.payload_1, f.payload_2, f.payload_3} = $urandom;
      {f.payload_4, f.payload_5, f.payload_6, f.payload_7} = $urandom;
      push_frame(f);
    end
  endtask

  // APB write, junk in the bits above the register width
  task automatic set_reg(rlctf_pkg::reg_idx_t r, int unsigned v);
    int unsigned mask;
    mask = (r == rlctf_pkg::REG_LIVE_ID_A || r == rlctf_pkg::REG_LIVE_ID_B) ? 32'h7FF
                                                                            : 32'hFFFF;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= ($urandom & ~mask) | (v & mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      rlctf_pkg::REG_LIVE_ID_A:    id_a     = v[10:0];
      rlctf_pkg::REG_LIVE_ID_B:    id_b     = v[10:0];
      rlctf_pkg::REG_MIN_PERIOD_A: period_a = v[15:0];
      rlctf_pkg::REG_MIN_PERIOD_B: period_b = v[15:0];
      default: ;
    endcase
  endtask

  task automatic set_all(int unsigned ia, int unsigned ib,
                         int unsigned pa, int unsigned pb);
    set_reg(rlctf_pkg::REG_LIVE_ID_A, ia);
    set_reg(rlctf_pkg::REG_LIVE_ID_B, ib);
    set_reg(rlctf_pkg::REG_MIN_PERIOD_A, pa);
    set_reg(rlctf_pkg::REG_MIN_PERIOD_B, pb);
    settings++;
  endtask

  // Wait for every queued item to go in and every byte to come out,
  // then give filtered frames time to clear the pipeline
  task automatic settle();
    while (frames_taken != frames_queued || bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: takes items from frames_todo, with random gap bursts
  always @(posedge clk) begin
    if (rst) begin
      can_valid <= 1'b0;
    end else begin
      if (can_valid && !can_stall) begin
        forward_frame(can_item);
        frames_taken++;
      end
      if (!can_valid || !can_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          can_valid <= 1'b0;
        end else if (frames_todo.size() != 0 && $urandom_range(1, 100) <= idle_pct) begin
          send_gap = $urandom_range(0, 17);
          can_valid <= 1'b0;
        end else if (frames_todo.size() != 0) begin
          can_item  <= frames_todo.pop_front();
          can_valid <= 1'b1;
        end else begin
          can_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each byte against bytes_due, stalls in random bursts
  always @(posedge clk) begin
    if (rst) begin
      tlm_stall <= 1'b0;
    end else begin
      if (tlm_valid && !tlm_stall) begin
        bytes_out++;
        if (tlm_item.frame_end === 1'b1) frames_out++;
        if (bytes_due.size() == 0) begin
          $error("unexpected item: out_byte %02h frame_end %0b",
                 tlm_item.out_byte, tlm_item.frame_end);
          errors++;
        end else begin
          byte_want = bytes_due.pop_front();
          if (tlm_item.out_byte !== byte_want.out_byte) begin
            $error("out_byte: expected %02h, got %02h",
                   byte_want.out_byte, tlm_item.out_byte);
            errors++;
          end
          if (tlm_item.frame_end !== byte_want.frame_end) begin
            $error("frame_end: expected %0b, got %0b",
                   byte_want.frame_end, tlm_item.frame_end);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        tlm_stall <= 1'b1;
      end else if ($urandom_range(1, 100) <= idle_pct) begin
        stall_left = $urandom_range(0, 17);
        tlm_stall <= 1'b1;
      end else begin
        tlm_stall <= 1'b0;
      end
    end
  end

  // Stimulus
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 25;

    // reset settings: period boundary, stale time, unknown IDs, lengths
    push_frame(mk_frame(11'd1320, 29'd0,   4'd8,  64'hFFFF_FFFF_FFFF_FFFF));
    push_frame(mk_frame(11'd1320, 29'd100, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF));
    push_frame(mk_frame(11'd1320, 29'd101, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF));
    push_frame(mk_frame(11'd48,   29'd101, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF));
    push_frame(mk_frame(11'd1320, 29'd201, 4'd8,  64'h0000_0000_0000_0000));
    push_frame(mk_frame(11'd1320, 29'd202, 4'd3,  64'h0807_0605_0403_0201));
    push_frame(mk_frame(11'd1320, 29'd50,  4'd8,  64'h1122_3344_5566_7788));
    push_frame(mk_frame(11'd0,    29'd5000, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    push_frame(mk_frame(11'h7FF,  TS_MAX,  4'd15, 64'hFFFF_FFFF_FFFF_FFFF));
    push_frame(mk_frame(11'd48,   29'd300, 4'd15, 64'hDEAD_BEEF_CAFE_F00D));
    push_frame(mk_frame(11'd48,   29'd401, 4'd9,  64'h0123_4567_89AB_CDEF));
    push_frame(mk_frame(11'd1320, 29'd1000, 4'd1, 64'hAA55_AA55_AA55_AA55));
    push_frame(mk_frame(11'd1320, 29'd2000, 4'd7, 64'h8040_2010_0804_0201));
    settle();

    // extreme IDs and periods
    set_all(32'h7FF, 32'h000, 32'h0000, 32'hFFFF);
    push_frame(mk_frame(11'h7FF, 29'd2001,  4'd8, 64'h0F0F_0F0F_F0F0_F0F0));
    push_frame(mk_frame(11'h7FF, 29'd2001,  4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    push_frame(mk_frame(11'd0,   29'd65936, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    push_frame(mk_frame(11'd0,   29'd65937, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    push_frame(mk_frame(11'd1320, 29'd70000, 4'd8, 64'h1234_5678_9ABC_DEF0));
    settle();

    // same ID in both registers: only the first entry may be used
    set_all(48, 48, 10, 1000);
    push_frame(mk_frame(11'd48, 29'd2012, 4'd8, 64'hA5A5_A5A5_5A5A_5A5A));
    push_frame(mk_frame(11'd48, 29'd2022, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    push_frame(mk_frame(11'd48, 29'd2023, 4'd5, 64'h7766_5544_3322_1100));
    settle();

    // random phases
    now_ms = 70000;
    idle_pct = 30;
    set_all($urandom_range(0, 2047), $urandom_range(0, 2047),
            $urandom_range(0, 300), $urandom_range(0, 300));
    push_random(34);
    settle();

    idle_pct = 10;
    set_all($urandom_range(0, 2047), $urandom_range(0, 2047), 0, 0);
    push_random(34);
    settle();

    idle_pct = 50;
    set_all(0, 2047, 65535, 65535);
    push_random(34);
    settle();

    // last part: no idling, timestamps climbing to the top of the range
    idle_pct = 0;
    set_all($urandom_range(0, 2047), $urandom_range(0, 2047),
            $urandom_range(0, 50), $urandom_range(0, 50));
    now_ms = TS_MAX - 3000;
    push_random(34);
    push_frame(mk_frame(id_a, TS_MAX, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    push_frame(mk_frame(id_b, TS_MAX, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    settle();

    if (bytes_due.size() != 0) begin
      $error("%0d expected items never arrived", bytes_due.size());
      errors++;
    end
    $display("run covered %0d CAN frames and %0d register settings,",
             frames_taken, settings);
    $display("giving %0d telemetry frames (%0d bytes) checked byte by byte",
             frames_out, bytes_out);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
